// ===== rtl/core/mspm_pkg.sv =====
// shared types and constants for the motor speed pid block
package mspm_pkg;

    localparam int GAIN_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int DUTY_W      = 9;
    localparam int MODE_W      = 2;
    localparam int INTEG_W     = 16;

    // request modes
    localparam logic [MODE_W-1:0] MODE_SPEED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KICK  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

    localparam int SLOW_LIMIT  = 100;
    localparam int DUTY_MAX    = 400;
    localparam int KICK_DUTY   = 350;
    localparam int INTEG_LIMIT = 32767;

    // sequencer to divider
    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] divisor;
    } div_ctl_t;

    // divider to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/core/mspm_div.sv =====
// radix-2 restoring signed divider by a 7-bit gain, truncating toward zero
module mspm_div
    import mspm_pkg::*;
#(
    parameter int DW = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_ctl_t             ctl,
    input  logic signed [DW-1:0] dividend,
    output div_stat_t            stat,
    output logic signed [DW-1:0] quotient
);

    localparam int CW = $clog2(DW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] mag_reg, mag_next;
    logic [GAIN_W-1:0] rem_reg, rem_next;
    logic [GAIN_W-1:0] dsr_reg, dsr_next;
    logic          neg_reg, neg_next;

    logic [GAIN_W:0] trial;
    logic            fits;

    assign trial = {rem_reg, mag_reg[DW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW - 1);
            neg_next  = dividend[DW-1];
            mag_next  = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
            rem_next  = '0;
            // a zero gain divides as one
            dsr_next  = (ctl.divisor == '0) ? GAIN_W'(1) : ctl.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? GAIN_W'(trial - {1'b0, dsr_reg}) : trial[GAIN_W-1:0];
            mag_next = {mag_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

// ===== rtl/core/motor_speed_pid_modes_unit.sv =====
// incremental pid speed controller with three modes and a shared serial divider
//
//  channel   signals                                  direction  beat
//  input     in_valid/in_ready, req_type, speed,      in         one control period
//            target_speed
//  output    out_valid/out_ready, duty                out        one duty value
//  config    cfg_we, cfg_addr, cfg_wdata              in         one gain write
//
//  modes 0 and 1 run two divisions one after the other on the single
//  bit-serial divider, one quotient bit per cycle; modes 2 and 3 skip
//  the divider and pass straight from the idle state to the output state
//  in_ready is high only while the sequencer is idle; one beat at a time
//  the finished duty sits in an output register, so a new beat is taken
//  while out_ready holds the previous one back
//  reset clears the controller history, gains go to 1; no clearing pass
module motor_speed_pid_modes_unit
    import mspm_pkg::*;
#(
    parameter int SPEED_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MODE_W-1:0]     req_type,
    input  logic [SPEED_BITS-1:0] speed,
    input  logic [SPEED_BITS-1:0] target_speed,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DUTY_W-1:0]     duty,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [GAIN_W-1:0]     cfg_wdata
);

    localparam int SW     = SPEED_BITS;
    localparam int EW     = SW + 1;                 // error
    localparam int DDW    = SW + 3;                 // second difference
    localparam int DIV_W  = (DDW > INTEG_W) ? DDW : INTEG_W;
    localparam int PROD_W = EW + GAIN_W;
    localparam int SUM_W  = ((PROD_W > DIV_W) ? PROD_W : DIV_W) + 2;

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV_A = 3'd1;
    localparam logic [2:0] S_MID   = 3'd2;
    localparam logic [2:0] S_DIV_B = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [SW-1:0]            SLOW_LIM = SW'(SLOW_LIMIT);
    localparam logic signed [DIV_W:0]    ILIM_HI  = (DIV_W+1)'(INTEG_LIMIT);
    localparam logic signed [DIV_W:0]    ILIM_LO  = -(DIV_W+1)'(INTEG_LIMIT);
    localparam logic signed [SUM_W-1:0]  DMAX     = SUM_W'(DUTY_MAX);

    logic [2:0]               state_reg, state_next;
    logic [GAIN_W-1:0]        gain_p_reg, gain_i_reg, gain_d_reg;
    logic [DUTY_W-1:0]        last_duty_reg;
    logic [SW-1:0]            prev1_reg, prev2_reg;
    logic signed [INTEG_W-1:0] integral_reg;

    // per-beat working registers
    logic [MODE_W-1:0]        mode_reg;
    logic [SW-1:0]            spd_reg;
    logic                     tgt_zero_reg;
    logic signed [EW-1:0]     err_reg;
    logic signed [DDW-1:0]    dd_reg;
    logic signed [DIV_W-1:0]  qa_reg, qb_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                     out_valid_reg;
    logic [DUTY_W-1:0]        duty_reg;

    logic                     accept;
    logic [SW-1:0]            spd_eff;
    logic signed [EW-1:0]     err_c;
    logic signed [DDW-1:0]    dd_c;
    logic signed [DIV_W:0]    integ_sum;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [SUM_W-1:0]  sum_c;
    logic [DUTY_W-1:0]        duty_c;
    logic                     out_free;

    div_ctl_t                 div_ctl;
    div_stat_t                div_stat;
    logic signed [DIV_W-1:0]  div_dividend;
    logic signed [DIV_W-1:0]  div_quot;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // slow speeds count as standing still in the loop modes
    assign spd_eff = (speed < SLOW_LIM) ? '0 : speed;
    assign err_c   = $signed({1'b0, target_speed}) - $signed({1'b0, spd_eff});
    assign dd_c    = $signed({2'b00, prev1_reg, 1'b0}) - $signed({3'b000, prev2_reg})
                   - $signed({3'b000, spd_eff});

    // integral update with saturation
    assign integ_sum  = (DIV_W+1)'(integral_reg) + (DIV_W+1)'(div_quot);
    assign integ_next = (integ_sum > ILIM_HI) ? INTEG_W'(ILIM_HI) :
                        (integ_sum < ILIM_LO) ? INTEG_W'(ILIM_LO) : INTEG_W'(integ_sum);

    // divider operands: first error, then integral or second difference
    always_comb
    begin
        div_ctl.start   = 1'b0;
        div_ctl.divisor = gain_p_reg;
        div_dividend    = DIV_W'(err_c);
        if (state_reg == S_IDLE)
        begin
            div_ctl.start   = accept && (req_type == MODE_SPEED || req_type == MODE_LINE);
            div_ctl.divisor = (req_type == MODE_SPEED) ? gain_i_reg : gain_p_reg;
            div_dividend    = DIV_W'(err_c);
        end
        else if (state_reg == S_MID)
        begin
            div_ctl.start   = 1'b1;
            div_ctl.divisor = (mode_reg == MODE_SPEED) ? gain_i_reg : gain_d_reg;
            div_dividend    = (mode_reg == MODE_SPEED) ? DIV_W'(integral_reg) : DIV_W'(dd_reg);
        end
    end

    // final duty: last duty plus the two terms, then overrides and clamp
    assign sum_c = SUM_W'($signed({1'b0, last_duty_reg}))
                 + ((mode_reg == MODE_SPEED) ? SUM_W'(prod_reg) : SUM_W'(qa_reg))
                 + SUM_W'(qb_reg);

    always_comb
    begin
        if (tgt_zero_reg)
            duty_c = '0;
        else if (mode_reg == MODE_LINE && err_reg < 0)
            duty_c = last_duty_reg;                 // over target: hold
        else if (sum_c < 0)
            duty_c = '0;
        else if (sum_c > DMAX)
            duty_c = DUTY_W'(DUTY_MAX);
        else
            duty_c = sum_c[DUTY_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = div_ctl.start ? S_DIV_A : S_OUT;
            end
            S_DIV_A:
            begin
                if (div_stat.done)
                    state_next = S_MID;
            end
            S_MID:
            begin
                state_next = S_DIV_B;
            end
            S_DIV_B:
            begin
                if (div_stat.done)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_p_reg    <= GAIN_W'(1);
            gain_i_reg    <= GAIN_W'(1);
            gain_d_reg    <= GAIN_W'(1);
            last_duty_reg <= '0;
            prev1_reg     <= '0;
            prev2_reg     <= '0;
            integral_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_GAIN_P: gain_p_reg <= cfg_wdata;
                    REG_GAIN_I: gain_i_reg <= cfg_wdata;
                    REG_GAIN_D: gain_d_reg <= cfg_wdata;
                    default:    ;
                endcase
            end

            // start-up kick stores the raw speed in the history
            if (accept && req_type == MODE_KICK)
            begin
                last_duty_reg <= DUTY_W'(KICK_DUTY);
                prev2_reg     <= prev1_reg;
                prev1_reg     <= speed;
            end

            if (state_reg == S_DIV_A && div_stat.done && mode_reg == MODE_SPEED)
                integral_reg <= integ_next;

            if (state_reg == S_SUM)
            begin
                last_duty_reg <= duty_c;
                prev2_reg     <= prev1_reg;
                prev1_reg     <= spd_reg;
            end

            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= req_type;
            spd_reg      <= spd_eff;
            tgt_zero_reg <= (target_speed == '0);
            err_reg      <= err_c;
            dd_reg       <= dd_c;
        end
        if (state_reg == S_DIV_A && div_stat.done)
            qa_reg <= div_quot;
        if (state_reg == S_MID)
            prod_reg <= err_reg * $signed({1'b0, gain_p_reg});
        if (state_reg == S_DIV_B && div_stat.done)
            qb_reg <= div_quot;
        if (state_reg == S_OUT && out_free)
            duty_reg <= last_duty_reg;
    end

    mspm_div #(
        .DW (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign out_valid = out_valid_reg;
    assign duty      = duty_reg;

    // divider is never restarted mid-division
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a quotient only arrives while the sequencer waits for one
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV_A || state_reg == S_DIV_B))
        else $error("divider result arrived outside a wait state");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        last_duty_reg <= DUTY_W'(DUTY_MAX))
        else $error("stored duty out of range");

    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (integral_reg <= INTEG_W'(INTEG_LIMIT)) && (integral_reg >= -INTEG_W'(INTEG_LIMIT)))
        else $error("integral beyond saturation limit");

    // one beat in flight: accepting closes the input until the result is out
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second beat accepted while busy");

endmodule
